// ===== rtl/glc_pkg.sv =====
// ----------------------------------------------------------------------------
// glc_pkg
// Shared constants and types of the glyph LRU tag store: entry layout, ring
// control bundle and walk sequencer states.
// ----------------------------------------------------------------------------
package glc_pkg;

    localparam int ENTRIES    = 64;
    localparam int KEY_W      = 32;
    localparam int SLOT_W     = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int SLOT_OUT_W = 6;
    localparam int OUT_DATA_W = 8;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot;
    } entry_t;

    typedef struct packed {
        logic   shift;
        logic   load;
        entry_t tail_d;
        entry_t front;
    } ring_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_WRITE
    } walk_state_t;

endpackage

// ===== rtl/glc_cell.sv =====
// ----------------------------------------------------------------------------
// glc_cell
// One stage of the recency ring: holds a key and its slot number and takes
// the entry offered by its neighbour when enabled.
// ----------------------------------------------------------------------------
module glc_cell (
    input  logic            clk,
    input  logic            en,
    input  glc_pkg::entry_t d,
    output glc_pkg::entry_t q
);
    import glc_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = en ? d : entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

// ===== rtl/glc_walk.sv =====
// ----------------------------------------------------------------------------
// glc_walk
// Walk sequencer: rotates the ring once per lookup, compares the entry at
// the observation point, ripples displaced entries back one place and writes
// the front entry when the rotation closes.
// ----------------------------------------------------------------------------
module glc_walk (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tuser,
    input  glc_pkg::entry_t       point,
    output glc_pkg::ring_ctl_t    ctl
);
    import glc_pkg::*;

    walk_state_t             state_reg, state_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    entry_t                  carry_reg, carry_next;
    logic [CNT_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    stop_reg, stop_next;
    logic                    hit_reg, hit_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SLOT_OUT_W-1:0]   out_slot_reg, out_slot_next;
    logic                    out_hit_reg, out_hit_next;

    logic                    full;
    logic                    in_list;
    logic                    at_free;
    logic                    match;
    logic                    out_free;
    logic                    swap;
    logic                    walk_end;
    logic [SLOT_W-1:0]       front_slot;

    always_comb
    begin
        full       = (count_reg == CNT_W'(ENTRIES));
        in_list    = (pos_reg < count_reg);
        at_free    = (pos_reg == count_reg) && !full;
        match      = (point.key == key_reg);
        out_free   = !out_valid_reg || m_tready;
        swap       = (state_reg == ST_WALK) && !stop_reg && (in_list || at_free);
        walk_end   = (pos_reg == CNT_W'(ENTRIES - 1));
        front_slot = (hit_reg || full) ? carry_reg.slot : count_reg[SLOT_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_end)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready         = 1'b0;
        ctl.shift        = 1'b0;
        ctl.load         = 1'b0;
        ctl.tail_d       = swap ? carry_reg : point;
        ctl.front.key    = key_reg;
        ctl.front.slot   = front_slot;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_WALK:
            begin
                ctl.shift = 1'b1;
            end
            ST_WRITE:
            begin
                ctl.load = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        key_next       = key_reg;
        carry_next     = carry_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        stop_next      = stop_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_slot_next  = out_slot_reg;
        out_hit_next   = out_hit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    key_next  = s_tdata;
                    pos_next  = '0;
                    stop_next = 1'b0;
                    hit_next  = 1'b0;
                end
            end
            ST_WALK:
            begin
                pos_next = pos_reg + CNT_W'(1);
                if (!stop_reg)
                begin
                    if (in_list)
                    begin
                        carry_next = point;
                        if (match)
                        begin
                            stop_next = 1'b1;
                            hit_next  = 1'b1;
                        end
                    end
                    else if (at_free)
                    begin
                        stop_next = 1'b1;
                    end
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = SLOT_OUT_W'(front_slot);
                    out_hit_next   = hit_reg;
                    if (!hit_reg && !full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            count_reg     <= '0;
            stop_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            stop_reg      <= stop_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        carry_reg    <= carry_next;
        out_slot_reg <= out_slot_next;
        out_hit_reg  <= out_hit_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - SLOT_OUT_W){1'b0}}, out_slot_reg};
    assign m_tuser  = out_hit_reg;

endmodule

// ===== rtl/glyph_lru_cache.sv =====
// ----------------------------------------------------------------------------
// glyph_lru_cache
// Fully associative LRU tag store for glyph slots, kept as a ring of cells in
// recency order with move-to-front on every lookup.
//
//   channel  dir  tdata                         tuser
//   s_*      in   [31:0] char_key               -
//   m_*      out  [5:0] slot, [7:6] zero        [0] hit
//
// A lookup takes the transfer, rotates the ring of cells once past the single
// compare point, then writes the front cell and loads the result register.
// No new key is taken until the result register is loaded.
// Reset clears the fill count and the sequencer; cell contents are undefined
// until filled and are never compared beyond the fill count.
// A stalled result holds the block in its final write cycle.
// ----------------------------------------------------------------------------
module glyph_lru_cache (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] char_key
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] slot, [7:6] zero
    output logic        m_tuser    // [0] hit
);
    import glc_pkg::*;

    entry_t    cell_q [ENTRIES];
    entry_t    cell_d [ENTRIES];
    logic      cell_en [ENTRIES];
    ring_ctl_t ctl;

    glc_walk u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .point    (cell_q[0]),
        .ctl      (ctl)
    );

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        if (i == 0)
        begin : g_front
            assign cell_d[i]  = ctl.load ? ctl.front : cell_q[i+1];
            assign cell_en[i] = ctl.shift || ctl.load;
        end
        else if (i == ENTRIES - 1)
        begin : g_tail
            assign cell_d[i]  = ctl.tail_d;
            assign cell_en[i] = ctl.shift;
        end
        else
        begin : g_mid
            assign cell_d[i]  = cell_q[i+1];
            assign cell_en[i] = ctl.shift;
        end

        glc_cell u_cell (
            .clk (clk),
            .en  (cell_en[i]),
            .d   (cell_d[i]),
            .q   (cell_q[i])
        );
    end

endmodule
